[sv/polygon_box_overlap_test_defines.svh]
// assertion macros for the polygon box overlap test block
// no dependencies; included by the modules that carry assertions
`ifndef POLYGON_BOX_OVERLAP_TEST_DEFINES_SVH
`define POLYGON_BOX_OVERLAP_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define PBO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PBO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBO_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PBO_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/pbo_pkg.sv]
// shared types, constants and width helpers for the polygon box overlap test
// no dependencies
package pbo_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int COORD_WIDTH  = 16;
  localparam int FIELD_W      = 16;
  localparam int BOX_W        = 15;
  localparam int IDX_W        = 3;
  localparam int CFG_W        = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic wrap;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic any_left;
    logic busy;
  } side_res_t;

  // 2*centre +/- extent
  function automatic int box_term_w(input int cw);
    return ((cw + 1 > BOX_W + 1) ? cw + 1 : BOX_W + 1) + 1;
  endfunction

  // corner offset from side start, doubled
  function automatic int offset_w(input int cw);
    return box_term_w(cw) + 1;
  endfunction

  function automatic int prod_w(input int cw);
    return cw + 1 + offset_w(cw);
  endfunction

endpackage

[sv/pbo_cell.sv]
// one vertex cell of the rotating ring
// depends on pbo_pkg
module pbo_cell #(
  parameter int COORD_WIDTH = pbo_pkg::COORD_WIDTH
) (
  input  logic                          clk,
  input  pbo_pkg::cell_ctl_t            ctl,
  input  logic signed [COORD_WIDTH-1:0] wr_x,
  input  logic signed [COORD_WIDTH-1:0] wr_y,
  input  logic signed [COORD_WIDTH-1:0] next_x,
  input  logic signed [COORD_WIDTH-1:0] next_y,
  input  logic signed [COORD_WIDTH-1:0] head_x,
  input  logic signed [COORD_WIDTH-1:0] head_y,
  output logic signed [COORD_WIDTH-1:0] x,
  output logic signed [COORD_WIDTH-1:0] y
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x <= wr_x;
      y <= wr_y;
    end else if (ctl.shift) begin
      // last live cell closes the ring from the head
      x <= ctl.wrap ? head_x : next_x;
      y <= ctl.wrap ? head_y : next_y;
    end
  end

endmodule

[sv/pbo_side_eval.sv]
// side evaluator: four box corners against one polygon side, two register stages
// depends on pbo_pkg
module pbo_side_eval #(
  parameter int COORD_WIDTH = pbo_pkg::COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic signed [pbo_pkg::box_term_w(COORD_WIDTH)-1:0] ax_p,
  input  logic signed [pbo_pkg::box_term_w(COORD_WIDTH)-1:0] ax_m,
  input  logic signed [pbo_pkg::box_term_w(COORD_WIDTH)-1:0] ay_p,
  input  logic signed [pbo_pkg::box_term_w(COORD_WIDTH)-1:0] ay_m,
  output pbo_pkg::side_res_t            res
);

  localparam int SW = COORD_WIDTH + 1;
  localparam int OW = pbo_pkg::offset_w(COORD_WIDTH);
  localparam int PW = pbo_pkg::prod_w(COORD_WIDTH);

  logic                 s1_valid;
  logic signed [SW-1:0] sx, sy;
  logic signed [OW-1:0] bxp, bxm, byp, bym;

  logic                 s2_valid;
  logic signed [PW-1:0] ps_p, ps_m, qs_p, qs_m;

  logic left_pp, left_mm, left_pm, left_mp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    sx  <= SW'(end_x) - SW'(start_x);
    sy  <= SW'(end_y) - SW'(start_y);
    bxp <= OW'(ax_p) - (OW'(start_x) <<< 1);
    bxm <= OW'(ax_m) - (OW'(start_x) <<< 1);
    byp <= OW'(ay_p) - (OW'(start_y) <<< 1);
    bym <= OW'(ay_m) - (OW'(start_y) <<< 1);
  end

  always_ff @(posedge clk) begin
    ps_p <= PW'(sx) * PW'(byp);
    ps_m <= PW'(sx) * PW'(bym);
    qs_p <= PW'(sy) * PW'(bxp);
    qs_m <= PW'(sy) * PW'(bxm);
  end

  // corner is left when sx*by > sy*bx
  assign left_pp = ps_p > qs_p;
  assign left_mm = ps_m > qs_m;
  assign left_pm = ps_m > qs_p;
  assign left_mp = ps_p > qs_m;

  assign res.valid    = s2_valid;
  assign res.any_left = left_pp | left_mm | left_pm | left_mp;
  assign res.busy     = s1_valid | s2_valid;

endmodule

[sv/polygon_box_overlap_test.sv]
// channel    | ports                                              | beat marked by
// -----------+----------------------------------------------------+-------------------
// command    | operation vertex_index vertex_x/y box_* (in)       | start & ~busy
// config     | cfg_wdata (in)                                     | cfg_we
// result     | overlaps (out)                                     | done, one cycle
//
// a load leaves busy low; a test holds busy while the vertex ring rotates once per
// side, n sides with n being vertex_count capped at MAX_VERTICES (none for an empty
// polygon), into the shared four-corner evaluator and while its two register stages
// drain. done pulses in the last busy cycle.
// rst is synchronous; it clears control and vertex_count, not the vertex cells.
// the receiver cannot stall, so done is never held.
// depends on pbo_pkg, pbo_cell, pbo_side_eval and the defines header
`include "polygon_box_overlap_test_defines.svh"
module polygon_box_overlap_test #(
  parameter int MAX_VERTICES = pbo_pkg::MAX_VERTICES,
  parameter int COORD_WIDTH  = pbo_pkg::COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic        [pbo_pkg::IDX_W-1:0]    vertex_index,
  input  logic signed [pbo_pkg::FIELD_W-1:0]  vertex_x,
  input  logic signed [pbo_pkg::FIELD_W-1:0]  vertex_y,
  input  logic signed [pbo_pkg::FIELD_W-1:0]  box_center_x,
  input  logic signed [pbo_pkg::FIELD_W-1:0]  box_center_y,
  input  logic        [pbo_pkg::BOX_W-1:0]    box_width,
  input  logic        [pbo_pkg::BOX_W-1:0]    box_height,
  input  logic                                cfg_we,
  input  logic        [pbo_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                                done,
  output logic                                overlaps
);

  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam int CmpW = (CntW > pbo_pkg::CFG_W) ? CntW : pbo_pkg::CFG_W;
  localparam int AW   = pbo_pkg::box_term_w(COORD_WIDTH);

  pbo_pkg::state_t state, state_next;
  logic [CntW-1:0] side_cnt, side_cnt_next;
  logic [pbo_pkg::CFG_W-1:0] vertex_count;
  logic acc;
  logic rotate;
  logic wr_stb;
  logic test_stb;

  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] max_ext;
  logic [CntW-1:0] n_eff;

  logic signed [COORD_WIDTH-1:0] wr_x, wr_y, cx_c, cy_c;
  logic signed [AW-1:0] ax_p, ax_m, ay_p, ay_m;

  logic signed [COORD_WIDTH-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] cell_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] end_x, end_y;

  pbo_pkg::side_res_t res;

  // count above the ring size uses the whole ring
  assign cnt_ext = CmpW'(vertex_count);
  assign max_ext = CmpW'(MAX_VERTICES);
  assign n_eff   = CntW'((cnt_ext > max_ext) ? max_ext : cnt_ext);

  assign wr_x = COORD_WIDTH'(vertex_x);
  assign wr_y = COORD_WIDTH'(vertex_y);
  assign cx_c = COORD_WIDTH'(box_center_x);
  assign cy_c = COORD_WIDTH'(box_center_y);

  assign wr_stb   = (state == pbo_pkg::ST_IDLE) && start && (operation == pbo_pkg::OP_LOAD);
  assign test_stb = (state == pbo_pkg::ST_IDLE) && start && (operation == pbo_pkg::OP_TEST);

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pbo_pkg::cell_ctl_t ctl;
    logic signed [COORD_WIDTH-1:0] nx, ny;

    if (i < (1 << pbo_pkg::IDX_W)) begin : g_addr
      assign ctl.load = wr_stb && (vertex_index == pbo_pkg::IDX_W'(i));
    end else begin : g_noaddr
      assign ctl.load = 1'b0;
    end

    if (i + 1 < MAX_VERTICES) begin : g_nb
      assign nx = cell_x[i + 1];
      assign ny = cell_y[i + 1];
    end else begin : g_end
      assign nx = cell_x[0];
      assign ny = cell_y[0];
    end

    assign ctl.shift = rotate && (CntW'(i) < n_eff);
    assign ctl.wrap  = (n_eff == CntW'(i + 1));

    pbo_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr_x   (wr_x),
      .wr_y   (wr_y),
      .next_x (nx),
      .next_y (ny),
      .head_x (cell_x[0]),
      .head_y (cell_y[0]),
      .x      (cell_x[i]),
      .y      (cell_y[i])
    );
  end

  // side runs head -> next; a single vertex closes on itself
  assign end_x = (n_eff == CntW'(1)) ? cell_x[0] : cell_x[1];
  assign end_y = (n_eff == CntW'(1)) ? cell_y[0] : cell_y[1];

  pbo_side_eval #(.COORD_WIDTH(COORD_WIDTH)) u_eval (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rotate),
    .start_x  (cell_x[0]),
    .start_y  (cell_y[0]),
    .end_x    (end_x),
    .end_y    (end_y),
    .ax_p     (ax_p),
    .ax_m     (ax_m),
    .ay_p     (ay_p),
    .ay_m     (ay_m),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (test_stb) begin
      ax_p <= (AW'(cx_c) <<< 1) + AW'($signed({1'b0, box_width}));
      ax_m <= (AW'(cx_c) <<< 1) - AW'($signed({1'b0, box_width}));
      ay_p <= (AW'(cy_c) <<< 1) + AW'($signed({1'b0, box_height}));
      ay_m <= (AW'(cy_c) <<< 1) - AW'($signed({1'b0, box_height}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pbo_pkg::ST_IDLE;
      side_cnt     <= '0;
      vertex_count <= '0;
      acc          <= 1'b1;
    end else begin
      state    <= state_next;
      side_cnt <= side_cnt_next;
      if (cfg_we) begin
        vertex_count <= cfg_wdata;
      end
      if (test_stb) begin
        acc <= 1'b1;
      end else if (res.valid && !res.any_left) begin
        acc <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    side_cnt_next = side_cnt;
    busy          = 1'b1;
    done          = 1'b0;
    rotate        = 1'b0;
    unique case (state)
      pbo_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && (operation == pbo_pkg::OP_TEST)) begin
          side_cnt_next = '0;
          state_next    = (n_eff == '0) ? pbo_pkg::ST_DRAIN : pbo_pkg::ST_ROTATE;
        end
      end
      pbo_pkg::ST_ROTATE: begin
        rotate        = 1'b1;
        side_cnt_next = side_cnt + CntW'(1);
        if (side_cnt == n_eff - CntW'(1)) begin
          state_next = pbo_pkg::ST_DRAIN;
        end
      end
      pbo_pkg::ST_DRAIN: begin
        if (!res.busy) begin
          done       = 1'b1;
          state_next = pbo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pbo_pkg::ST_IDLE;
      end
    endcase
  end

  assign overlaps = acc;

  `PBO_ASSERT_NOW(a_cnt_range, clk, rst, state == pbo_pkg::ST_ROTATE,
    side_cnt < n_eff, "side counter ran past the vertex count")
  `PBO_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy,
    "block still busy after its result beat")
  `PBO_ASSERT_NEXT(a_empty_poly, clk, rst,
    start && !busy && (operation == pbo_pkg::OP_TEST) && (n_eff == '0),
    done && overlaps, "empty polygon did not report overlap at once")
  `PBO_ASSERT_NOW(a_eval_live, clk, rst, res.valid,
    state != pbo_pkg::ST_IDLE, "side result arrived outside a test")

endmodule
